@@ sv/rpo_pkg.sv @@
// Shared types and constants for the RGB pixel point operations block.
package rpo_pkg;

   // Opcodes of the input beat
   localparam logic [1:0] OP_GRAY   = 2'd0;
   localparam logic [1:0] OP_MONO   = 2'd1;
   localparam logic [1:0] OP_NEGATE = 2'd2;
   localparam logic [1:0] OP_PASS   = 2'd3;

   // Q0.16 luma weights, summing to 65536
   localparam logic [15:0] LUMA_WR = 16'd19595;
   localparam logic [15:0] LUMA_WG = 16'd38470;
   localparam logic [15:0] LUMA_WB = 16'd7471;

   localparam logic [7:0] MAX_COLOUR_RESET = 8'd255;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

endpackage

@@ sv/rgb_pixel_point_ops.sv @@
// Top level of the RGB pixel point operations block.
// One pixel is taken on every clock at which start is high; busy is never raised, so
// the block runs at one pixel per clock. Each result appears on rsp_data with
// rsp_strobe high for exactly one cycle, after the pixel has passed into the input
// register and then through the grayscale, monochrome, negative or pass-through
// logic into the result register. The receiver cannot stall, so every result must
// be taken in the cycle its strobe is high. max_colour resets to 255; the user must
// write it by csr_we/csr_wdata only while no pixels are in flight (unenforced).
module rgb_pixel_point_ops (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rpo_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rpo_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [7:0]       csr_wdata
);
   import rpo_pkg::*;

   logic [7:0] max_ff;
   logic       valid_ff;
   req_type    req_ff;
   logic       strobe_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;

   logic [23:0] luma_acc;
   logic [7:0]  luma;
   logic [9:0]  chan_sum;
   logic [9:0]  half_p1;
   logic [9:0]  mono_thresh;
   logic [7:0]  mono;

   // Never stalls
   assign busy = 1'b0;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_COLOUR_RESET;
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      if (start) begin
         req_ff <= req_data;
      end
   end

   // Grayscale: weighted sum, top byte of the Q8.16 result
   assign luma_acc = (24'(LUMA_WR) * 24'(req_ff.red_in))
                   + (24'(LUMA_WG) * 24'(req_ff.green_in))
                   + (24'(LUMA_WB) * 24'(req_ff.blue_in));
   assign luma = luma_acc[23:16];

   // Monochrome: floor(sum/3) > h  <=>  sum >= 3*(h+1)
   assign chan_sum    = 10'(req_ff.red_in) + 10'(req_ff.green_in) + 10'(req_ff.blue_in);
   assign half_p1     = 10'(max_ff[7:1]) + 10'd1;
   assign mono_thresh = (half_p1 << 1) + half_p1;
   assign mono        = (chan_sum >= mono_thresh) ? max_ff : 8'd0;

   // Operation select
   always_comb begin
      case (req_ff.opcode)
         OP_GRAY: begin
            rsp_in = '{red_out: luma, green_out: luma, blue_out: luma};
         end
         OP_MONO: begin
            rsp_in = '{red_out: mono, green_out: mono, blue_out: mono};
         end
         OP_NEGATE: begin
            rsp_in = '{red_out:   max_ff - req_ff.red_in,
                       green_out: max_ff - req_ff.green_in,
                       blue_out:  max_ff - req_ff.blue_in};
         end
         default: begin
            // unused opcode passes the pixel through
            rsp_in = '{red_out:   req_ff.red_in,
                       green_out: req_ff.green_in,
                       blue_out:  req_ff.blue_in};
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_ff;
      end
      if (valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

@@ sv/rpo_checker.sv @@
// Port-level checks for the RGB pixel point operations block, bound to the top level.
module rpo_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rpo_pkg::req_type req_data,
   input logic             rsp_strobe,
   input rpo_pkg::rsp_type rsp_data
);
   import rpo_pkg::*;

   // Every accepted beat is followed by a result strobe
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("accepted beat produced no result");

   // No result without an earlier accepted beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without accepted beat");

   // Grey input stays the same grey
   a_grey_fixed: assert property (@(posedge clock) disable iff (reset)
      ##2 (rsp_strobe && $past(start && !busy && req_data.opcode == OP_GRAY
            && req_data.red_in == req_data.green_in
            && req_data.green_in == req_data.blue_in, 2))
      |-> (rsp_data.red_out == $past(req_data.red_in, 2)
           && rsp_data.green_out == rsp_data.red_out
           && rsp_data.blue_out == rsp_data.red_out))
      else $error("grayscale of a grey pixel changed it");

   // Unused opcode passes the pixel through
   a_pass: assert property (@(posedge clock) disable iff (reset)
      ##2 (rsp_strobe && $past(start && !busy && req_data.opcode == OP_PASS, 2))
      |-> (rsp_data.red_out == $past(req_data.red_in, 2)
           && rsp_data.green_out == $past(req_data.green_in, 2)
           && rsp_data.blue_out == $past(req_data.blue_in, 2)))
      else $error("pass-through pixel altered");

endmodule

bind rgb_pixel_point_ops rpo_checker u_rpo_checker (.*);

@@ tb/rgb_pixel_point_ops_tb.sv @@
// Self-checking testbench for the RGB pixel point operations block.
`timescale 1ns / 1ps

module rgb_pixel_point_ops_tb;
   import rpo_pkg::*;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   req_type    req_data  = '0;
   logic       csr_we    = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   logic       busy;
   logic       rsp_strobe;
   rsp_type    rsp_data;

   rgb_pixel_point_ops dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Pixels waiting to be driven, and pixels the block should return
   req_type    pixels_to_send[$];
   rsp_type    predicted_pixels[$];
   logic [7:0] colour_max = MAX_COLOUR_RESET;   // shadow of the max_colour register

   int  gap_left   = 0;
   bit  no_idle    = 1'b0;
   int  errors     = 0;
   int  checked    = 0;
   int  op_seen[4] = '{0, 0, 0, 0};

   // Expected output pixel for one input beat at a given max_colour
   function automatic rsp_type transform_pixel(req_type px, logic [7:0] maxc);
      logic [31:0] luma_acc;
      logic [9:0]  chan_sum;
      logic [7:0]  level;
      rsp_type     px_out;
      case (px.opcode)
         OP_GRAY: begin
            luma_acc = 32'(LUMA_WR) * 32'(px.red_in) + 32'(LUMA_WG) * 32'(px.green_in)
                     + 32'(LUMA_WB) * 32'(px.blue_in);
            level = luma_acc[23:16];
            px_out = '{level, level, level};
         end
         OP_MONO: begin
            chan_sum = 10'(px.red_in) + 10'(px.green_in) + 10'(px.blue_in);
            level = ((chan_sum / 10'd3) > 10'(maxc >> 1)) ? maxc : 8'd0;
            px_out = '{level, level, level};
         end
         OP_NEGATE: begin
            // wraps mod 256 when a channel exceeds the maximum
            px_out.red_out   = 8'(maxc - px.red_in);
            px_out.green_out = 8'(maxc - px.green_in);
            px_out.blue_out  = 8'(maxc - px.blue_in);
         end
         default: px_out = '{px.red_in, px.green_in, px.blue_in};
      endcase
      return px_out;
   endfunction

   // Channel value biased towards the edges and the current maximum
   function automatic logic [7:0] pick_channel(logic [7:0] maxc);
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'hFF;
         2:       return maxc;
         3:       return 8'(maxc + 8'd1);
         4:       return 8'(maxc - 8'd1);
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type random_pixel(logic [7:0] maxc);
      req_type    px;
      logic [7:0] mid;
      px.opcode = 2'($urandom_range(OP_GRAY, OP_PASS));
      if ($urandom_range(0, 5) == 0) begin
         // grey-ish pixel sitting on the monochrome threshold
         mid = 8'((maxc >> 1) + $urandom_range(0, 1));
         px.red_in   = mid;
         px.green_in = mid;
         px.blue_in  = 8'(mid + $urandom_range(0, 2) - 1);
      end else begin
         px.red_in   = pick_channel(maxc);
         px.green_in = pick_channel(maxc);
         px.blue_in  = pick_channel(maxc);
      end
      return px;
   endfunction

   function automatic logic [7:0] sweep_value(int idx);
      case (idx)
         0:       return 8'd1;
         1:       return 8'd0;
         2:       return 8'd128;
         3:       return 8'd127;
         4:       return 8'd100;
         5:       return 8'd254;
         6:       return 8'($urandom_range(2, 253));
         default: return 8'd255;
      endcase
   endfunction

   task automatic queue_pixel(logic [1:0] op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixels_to_send.push_back('{op, r, g, b});
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         pixels_to_send.push_back(random_pixel(colour_max));
   endtask

   // Block until every queued pixel has gone in and come back out
   task automatic wait_drained();
      while (pixels_to_send.size() != 0 || start || predicted_pixels.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s channel mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Driver: one beat per accepted start, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            predicted_pixels.push_back(transform_pixel(req_data, colour_max));
            op_seen[req_data.opcode]++;
         end
         if (start && busy) begin
            // hold the beat until taken
         end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pixels_to_send.size() != 0) begin
            req_data <= pixels_to_send.pop_front();
            start    <= 1'b1;
            if ($urandom_range(0, 24) == 0)
               no_idle = !no_idle;
            gap_left <= no_idle ? 0 : $urandom_range(0, 10);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_pixels.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, rsp_data);
            errors++;
         end else begin
            want = predicted_pixels.pop_front();
            check_channel("red",   want.red_out,   rsp_data.red_out);
            check_channel("green", want.green_out, rsp_data.green_out);
            check_channel("blue",  want.blue_out,  rsp_data.blue_out);
            checked++;
         end
      end
   end

   // Stimulus: directed pixels at reset value, then a sweep of max_colour settings
   initial begin
      logic [7:0] new_max;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extremes of every operation, unused opcode included
      for (int op = OP_GRAY; op <= OP_PASS; op++) begin
         queue_pixel(2'(op), 8'd0,   8'd0,   8'd0);
         queue_pixel(2'(op), 8'd255, 8'd255, 8'd255);
         queue_pixel(2'(op), 8'd255, 8'd0,   8'd0);
         queue_pixel(2'(op), 8'd0,   8'd255, 8'd0);
         queue_pixel(2'(op), 8'd0,   8'd0,   8'd255);
      end
      // monochrome either side of the threshold
      queue_pixel(OP_MONO, 8'd127, 8'd127, 8'd127);
      queue_pixel(OP_MONO, 8'd128, 8'd128, 8'd128);
      queue_pixel(OP_MONO, 8'd128, 8'd127, 8'd127);
      queue_random(130);
      wait_drained();

      for (int s = 0; s < 8; s++) begin
         new_max = sweep_value(s);
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_wdata <= new_max;
         @(posedge clock);
         csr_we     <= 1'b0;
         colour_max = new_max;
         // negative of channels above a lowered maximum
         if (new_max == 8'd100)
            queue_pixel(OP_NEGATE, 8'd200, 8'd101, 8'd100);
         queue_random(130);
         wait_drained();
      end

      $display("Drove %0d pixels (gray %0d, mono %0d, negate %0d, pass %0d) across nine",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
               op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("max_colour settings incl. 0, 1 and 255; %0d results checked, %0d errors.",
               checked, errors);
      if (errors == 0)
         $display("** rgb_pixel_point_ops: PASSED **");
      else
         $display("** rgb_pixel_point_ops: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #500000;
      $display("Timed out waiting for results.");
      $display("** rgb_pixel_point_ops: FAILED **");
      $finish;
   end

endmodule
